### src/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg: shared types and codes of the flight mode sequencer
// Beat payloads, configuration set, sequencer state and the mode, event,
// duty and register index codes used across the files of the block.
// ----------------------------------------------------------------------------
package fms_pkg;

   // Flight modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_CALIB   = 3'd1;
   localparam logic [2:0] MODE_TAKEOFF = 3'd2;
   localparam logic [2:0] MODE_FLYING  = 3'd3;
   localparam logic [2:0] MODE_LANDING = 3'd4;

   // Button events
   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_UP    = 3'd1;
   localparam logic [2:0] EV_DOWN  = 3'd2;
   localparam logic [2:0] EV_LEFT  = 3'd3;
   localparam logic [2:0] EV_RIGHT = 3'd4;

   // Duty override codes
   localparam logic [1:0] DUTY_NONE = 2'd0;
   localparam logic [1:0] DUTY_ZERO = 2'd1;
   localparam logic [1:0] DUTY_CAL  = 2'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ALT_STEP        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_STEP        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAKEOFF_ALT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALT_MAX         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_TOLERANCE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_TAIL_DUTY = 3'd5;

   // Reset values of the configuration registers
   localparam logic [5:0] ALT_STEP_RESET      = 6'd10;
   localparam logic [7:0] YAW_STEP_RESET      = 8'd10;
   localparam logic [6:0] TAKEOFF_ALT_RESET   = 7'd10;
   localparam logic [6:0] ALT_MAX_RESET       = 7'd100;
   localparam logic [6:0] YAW_TOLERANCE_RESET = 7'd5;

   typedef struct packed {
      logic [2:0]         mode;
      logic               power_on;
      logic               yaw_ref_found;
      logic signed [7:0]  current_alt_pct;
      logic signed [15:0] current_yaw_deg;
   } req_type;

   typedef struct packed {
      logic [2:0]         flight_mode;
      logic signed [15:0] target_yaw_out;
      logic [6:0]         target_alt_out;
      logic [1:0]         duty_override;
      logic               alt_cal_request;
      logic               yaw_zero_request;
   } rsp_type;

   typedef struct packed {
      logic [5:0] alt_step;
      logic [7:0] yaw_step;
      logic [6:0] takeoff_alt;
      logic [6:0] alt_max;
      logic [6:0] yaw_tolerance;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        yaw_done;
      logic [15:0] yaw_target;
      logic [6:0]  alt_target;
   } state_type;

endpackage

### src/fms_csr.sv
// ----------------------------------------------------------------------------
// fms_csr: configuration registers of the flight mode sequencer
// Holds the step sizes, altitude limits and yaw tolerance; always ready.
// ----------------------------------------------------------------------------
module fms_csr
   import fms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // The tail calibration duty register is accepted but drives no output,
   // so it is not stored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ALT_STEP:        cfg_in.alt_step      = csr_wdata[5:0];
            CSR_YAW_STEP:        cfg_in.yaw_step      = csr_wdata[7:0];
            CSR_TAKEOFF_ALT:     cfg_in.takeoff_alt   = csr_wdata[6:0];
            CSR_ALT_MAX:         cfg_in.alt_max       = csr_wdata[6:0];
            CSR_YAW_TOLERANCE:   cfg_in.yaw_tolerance = csr_wdata[6:0];
            CSR_CALIB_TAIL_DUTY: cfg_in = cfg_ff;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alt_step      <= ALT_STEP_RESET;
         cfg_ff.yaw_step      <= YAW_STEP_RESET;
         cfg_ff.takeoff_alt   <= TAKEOFF_ALT_RESET;
         cfg_ff.alt_max       <= ALT_MAX_RESET;
         cfg_ff.yaw_tolerance <= YAW_TOLERANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/fms_step.sv
// ----------------------------------------------------------------------------
// fms_step: one control tick of the flight mode sequencer
// Combinational next state and result for a single beat.
// ----------------------------------------------------------------------------
module fms_step
   import fms_pkg::*;
(
   input  cfg_type   cfg,
   input  state_type cur,
   input  req_type   req,
   output state_type nxt,
   output rsp_type   rsp
);

   logic [16:0] yaw_dec;
   logic [16:0] yaw_inc;
   logic [16:0] yaw_abs;
   logic [7:0]  alt_sum;
   logic [6:0]  alt_new;
   logic [1:0]  duty;
   logic        cal_req;
   logic        zero_req;

   always_comb begin
      yaw_dec = {cur.yaw_target[15], cur.yaw_target} - {9'd0, cfg.yaw_step};
      yaw_inc = {cur.yaw_target[15], cur.yaw_target} + {9'd0, cfg.yaw_step};
      yaw_abs = req.current_yaw_deg[15] ? (17'd0 - {1'b1, req.current_yaw_deg})
                                        : {1'b0, req.current_yaw_deg};
      alt_sum = {1'b0, cur.alt_target} + {2'd0, cfg.alt_step};

      nxt      = cur;
      duty     = DUTY_NONE;
      cal_req  = 1'b0;
      zero_req = 1'b0;
      alt_new  = cur.alt_target;

      case (cur.mode)
         MODE_CALIB: begin
            if (req.power_on) begin
               cal_req = 1'b1;
               duty    = DUTY_CAL;
               if (req.yaw_ref_found) begin
                  zero_req     = 1'b1;
                  nxt.yaw_done = 1'b1;
                  nxt.mode     = MODE_TAKEOFF;
               end
            end else begin
               nxt.mode = MODE_IDLE;
            end
         end
         MODE_TAKEOFF: begin
            if (req.power_on) begin
               nxt.yaw_target = 16'd0;
               nxt.alt_target = cfg.takeoff_alt;
               if (!req.current_alt_pct[7] && (req.current_alt_pct[6:0] >= cfg.takeoff_alt)) begin
                  nxt.mode = MODE_FLYING;
               end
            end else begin
               nxt.mode = MODE_LANDING;
            end
         end
         MODE_FLYING: begin
            if (req.power_on) begin
               if (req.mode == EV_LEFT) begin
                  // Saturate when the 17-bit result leaves the 16-bit range
                  if (yaw_dec[16] != yaw_dec[15]) begin
                     nxt.yaw_target = 16'h8000;
                  end else begin
                     nxt.yaw_target = yaw_dec[15:0];
                  end
               end else if (req.mode == EV_RIGHT) begin
                  if (yaw_inc[16] != yaw_inc[15]) begin
                     nxt.yaw_target = 16'h7FFF;
                  end else begin
                     nxt.yaw_target = yaw_inc[15:0];
                  end
               end else if (req.mode == EV_UP) begin
                  if (cur.alt_target < cfg.alt_max) begin
                     alt_new = (alt_sum > {1'b0, cfg.alt_max}) ? cfg.alt_max : alt_sum[6:0];
                  end
               end else if (req.mode == EV_DOWN) begin
                  if (cur.alt_target > {1'b0, cfg.alt_step}) begin
                     alt_new = cur.alt_target - {1'b0, cfg.alt_step};
                  end else begin
                     alt_new = 7'd0;
                  end
               end
               if (alt_new < cfg.takeoff_alt) begin
                  nxt.alt_target = cfg.takeoff_alt;
                  nxt.mode       = MODE_LANDING;
               end else begin
                  nxt.alt_target = alt_new;
               end
            end else begin
               nxt.mode = MODE_LANDING;
            end
         end
         MODE_LANDING: begin
            nxt.yaw_target = 16'd0;
            if (yaw_abs < {10'd0, cfg.yaw_tolerance}) begin
               nxt.alt_target = 7'd0;
               if (req.current_alt_pct[7] || (req.current_alt_pct == 8'sd0)) begin
                  nxt.mode = MODE_IDLE;
               end
            end
         end
         default: begin
            // Idle, and any unused mode code behaves as idle
            nxt.mode = MODE_IDLE;
            duty     = DUTY_ZERO;
            if (req.power_on && (req.mode == EV_UP)) begin
               nxt.mode = cur.yaw_done ? MODE_TAKEOFF : MODE_CALIB;
            end
         end
      endcase

      rsp.flight_mode      = nxt.mode;
      rsp.target_yaw_out   = nxt.yaw_target;
      rsp.target_alt_out   = nxt.alt_target;
      rsp.duty_override    = duty;
      rsp.alt_cal_request  = cal_req;
      rsp.yaw_zero_request = zero_req;
   end

endmodule

### src/flight_mode_sequencer.sv
// ----------------------------------------------------------------------------
// flight_mode_sequencer: a request beat passes the input register, then the result register.
// Throughput one beat per cycle while rsp_ready keeps up; the tick update is fed by the input register.
// Synchronous active-high reset: mode idle, uncalibrated, targets 0, no beats.
// ----------------------------------------------------------------------------
//
// Structure
//   A request beat is captured in the input register. While it is held there
//   the tick logic reads that beat together with the sequencer state and the
//   configuration, updates the state and loads the result register. The
//   input register moves on whenever the result register is empty or its
//   beat is being taken in the same cycle, so a new request is accepted in
//   every cycle while the response side keeps up, and still while a finished
//   response waits, as long as the input register is free.
//
//   The state (mode, calibrated flag, yaw and altitude targets) changes only
//   when a tick is actually executed, so ticks are applied strictly in the
//   order their beats were accepted, whatever the stalling on either side.
//
//   Configuration writes are always taken and act on the next tick executed.
//   There is no memory and no clearing pass after reset.
//
module flight_mode_sequencer
   import fms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg;
   state_type state_ff;
   state_type state_in;
   rsp_type   step_rsp;

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_data_ff;
   logic      advance;

   fms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fms_step u_step (
      .cfg (cfg),
      .cur (state_ff),
      .req (in_data_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   // The held tick is executed when the result register can take its result.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_IDLE, yaw_done: 1'b0, yaw_target: 16'd0,
                           alt_target: 7'd0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // An executed tick always leaves a response in the result register.
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid)
      else $error("executed tick did not produce a response beat");

   // Both rotors are forced to zero only on an idle tick, which can lead only
   // to idle, calibrate or takeoff.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.duty_override == DUTY_ZERO)) |->
      ((rsp_data.flight_mode == MODE_IDLE) || (rsp_data.flight_mode == MODE_CALIB) ||
       (rsp_data.flight_mode == MODE_TAKEOFF)))
      else $error("zero duty override outside an idle tick");

   // Yaw zeroing ends calibration: it comes with the altitude request and
   // the move to takeoff.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.yaw_zero_request) |->
      (rsp_data.alt_cal_request && (rsp_data.flight_mode == MODE_TAKEOFF) &&
       (rsp_data.duty_override == DUTY_CAL)))
      else $error("yaw zero request outside the end of calibration");

   // Once calibrated, the flag never clears.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.yaw_done |=> state_ff.yaw_done)
      else $error("calibrated flag cleared without reset");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the flight mode sequencer
// Drives control ticks through the request channel, with random gaps on
// both sides, keeps its own model of the sequencer and checks every
// response beat field by field.
// ----------------------------------------------------------------------------
module tb;
   import fms_pkg::*;

   // Event codes above right are not buttons; the sequencer treats them as no event.
   localparam logic [2:0] EV_JUNK_LO  = 3'd5;
   localparam logic [2:0] EV_JUNK_MID = 3'd6;
   localparam logic [2:0] EV_JUNK_HI  = 3'd7;

   // Register indexes with no register behind them.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int CALIB_TAIL_RESET = 20;
   localparam int STALL_LIMIT      = 1000;
   localparam int SETTLE_CYCLES    = 6;
   localparam int REPORT_LIMIT     = 10;
   localparam int STALL_ODDS [3]   = '{0, 8, 3};

   // One planned tick: the request beat and, for the hand-written rows of the
   // directed table, the response that is expected for it.
   typedef struct packed {
      req_type beat;
      bit      typed;
      rsp_type want;
   } tick_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   flight_mode_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Our own copy of the sequencer state and of its configuration.
   logic [2:0] fm_mode = MODE_IDLE;
   bit         fm_calibrated = 1'b0;
   int         fm_yaw = 0;
   int         fm_alt = 0;
   int         cfg_alt_step = ALT_STEP_RESET;
   int         cfg_yaw_step = YAW_STEP_RESET;
   int         cfg_takeoff_alt = TAKEOFF_ALT_RESET;
   int         cfg_alt_max = ALT_MAX_RESET;
   int         cfg_yaw_tol = YAW_TOLERANCE_RESET;

   tick_row_type tick_plan_q [$];
   rsp_type      tick_expect_q [$];
   rsp_type      oldest_want;

   int         mismatches = 0;
   int         beats_in = 0;
   int         beats_out = 0;
   int         reg_writes = 0;
   int         settings = 0;
   int         yaw_clips = 0;
   bit [7:0]   modes_seen = '0;
   int         send_gap_odds = 0;
   bit         calm = 1'b0;
   bit         lean_right = 1'b1;

   // Saturate a yaw target to the 16-bit signed range, counting each clip.
   function automatic int clip_yaw(int v);
      if (v > 32767) begin
         yaw_clips++;
         return 32767;
      end
      if (v < -32768) begin
         yaw_clips++;
         return -32768;
      end
      return v;
   endfunction

   // Run one control tick on the local state and return the response it gives.
   // Exactly one mode's actions are taken per tick, and the mode and target
   // outputs are taken after the update.
   function automatic rsp_type advance_tick(req_type t);
      logic [2:0] ev;
      int         alt_now;
      int         yaw_now;
      int         err;
      rsp_type    r;
      ev = t.mode;
      if (ev > EV_RIGHT) ev = EV_NONE;
      alt_now = $signed(t.current_alt_pct);
      yaw_now = $signed(t.current_yaw_deg);
      r = '0;
      case (fm_mode)
         MODE_CALIB: begin
            if (t.power_on) begin
               r.alt_cal_request = 1'b1;
               r.duty_override = DUTY_CAL;
               if (t.yaw_ref_found) begin
                  r.yaw_zero_request = 1'b1;
                  fm_calibrated = 1'b1;
                  fm_mode = MODE_TAKEOFF;
               end
            end else begin
               fm_mode = MODE_IDLE;
            end
         end
         MODE_TAKEOFF: begin
            if (t.power_on) begin
               fm_yaw = 0;
               fm_alt = cfg_takeoff_alt;
               if (alt_now >= cfg_takeoff_alt) fm_mode = MODE_FLYING;
            end else begin
               fm_mode = MODE_LANDING;
            end
         end
         MODE_FLYING: begin
            if (t.power_on) begin
               if (ev == EV_LEFT) begin
                  fm_yaw = clip_yaw(fm_yaw - cfg_yaw_step);
               end else if (ev == EV_RIGHT) begin
                  fm_yaw = clip_yaw(fm_yaw + cfg_yaw_step);
               end else if (ev == EV_UP) begin
                  if (fm_alt < cfg_alt_max)
                     fm_alt = (fm_alt + cfg_alt_step > cfg_alt_max) ?
                              cfg_alt_max : fm_alt + cfg_alt_step;
               end else if (ev == EV_DOWN) begin
                  fm_alt = (fm_alt > cfg_alt_step) ? fm_alt - cfg_alt_step : 0;
               end
               // Dropping below the takeoff altitude ends the flight.
               if (fm_alt < cfg_takeoff_alt) begin
                  fm_alt = cfg_takeoff_alt;
                  fm_mode = MODE_LANDING;
               end
            end else begin
               fm_mode = MODE_LANDING;
            end
         end
         MODE_LANDING: begin
            // The switch is ignored here; descent waits for the yaw to settle.
            fm_yaw = 0;
            err = (yaw_now < 0) ? -yaw_now : yaw_now;
            if (err < cfg_yaw_tol) begin
               fm_alt = 0;
               if (alt_now < 1) fm_mode = MODE_IDLE;
            end
         end
         default: begin
            fm_mode = MODE_IDLE;
            r.duty_override = DUTY_ZERO;
            if (t.power_on && ev == EV_UP)
               fm_mode = fm_calibrated ? MODE_TAKEOFF : MODE_CALIB;
         end
      endcase
      modes_seen[fm_mode] = 1'b1;
      r.flight_mode = fm_mode;
      r.target_yaw_out = 16'(fm_yaw);
      r.target_alt_out = 7'(fm_alt);
      return r;
   endfunction

   function automatic rsp_type outcome(logic [2:0] mode_code, int yaw_val, int alt_val,
                                       logic [1:0] duty, bit cal, bit zero);
      rsp_type r;
      r.flight_mode = mode_code;
      r.target_yaw_out = 16'(yaw_val);
      r.target_alt_out = 7'(alt_val);
      r.duty_override = duty;
      r.alt_cal_request = cal;
      r.yaw_zero_request = zero;
      return r;
   endfunction

   function automatic tick_row_type row(logic [2:0] ev, bit pwr, bit seen_ref, int alt,
                                        int yaw, bit typed = 1'b0, rsp_type want = '0);
      tick_row_type r;
      r.beat.mode = ev;
      r.beat.power_on = pwr;
      r.beat.yaw_ref_found = seen_ref;
      r.beat.current_alt_pct = 8'(alt);
      r.beat.current_yaw_deg = 16'(yaw);
      r.typed = typed;
      r.want = want;
      return r;
   endfunction

   function automatic int any_alt();
      return int'($urandom_range(0, 255)) - 128;
   endfunction

   function automatic int any_yaw();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int alt_between(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic logic [2:0] any_event();
      return 3'($urandom_range(0, 7));
   endfunction

   function automatic bit coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // A measured yaw inside the landing tolerance, of either sign.
   function automatic int yaw_near_zero();
      int m;
      m = (cfg_yaw_tol > 0) ? int'($urandom_range(0, cfg_yaw_tol - 1)) : 0;
      return coin() ? -m : m;
   endfunction

   // Plan one well-formed flight with random content: ground ticks, an up
   // press with the switch on, takeoff, usually a spell of flying, switch off and a
   // landing that first waits on the yaw and then touches down. The block is
   // already calibrated by the directed part, and stays so, since only reset
   // clears the calibrated flag.
   task automatic plan_flight();
      int         hops;
      bit         longhaul;
      logic [2:0] lean;
      logic [2:0] ev;
      // With the largest yaw step, long flights leaning one way drive the yaw
      // target into its limit; the lean swaps from one flight to the next.
      longhaul = (cfg_yaw_step > 200);
      repeat ($urandom_range(0, 2))
         tick_plan_q.push_back(row(any_event(), 1'b0, coin(), any_alt(), any_yaw()));
      tick_plan_q.push_back(row(EV_UP, 1'b1, coin(), any_alt(), any_yaw()));
      if (cfg_takeoff_alt > 0)
         repeat ($urandom_range(0, 3))
            tick_plan_q.push_back(row(any_event(), 1'b1, coin(),
                                      alt_between(-128, cfg_takeoff_alt - 1), any_yaw()));
      if ($urandom_range(0, 9) == 0) begin
         // Switch off during takeoff sends the block straight to landing.
         tick_plan_q.push_back(row(any_event(), 1'b0, coin(), any_alt(), any_yaw()));
      end else begin
         tick_plan_q.push_back(row(any_event(), 1'b1, coin(),
                                   alt_between(cfg_takeoff_alt, 127), any_yaw()));
         lean = lean_right ? EV_RIGHT : EV_LEFT;
         if (longhaul) lean_right = !lean_right;
         hops = longhaul ? 150 : int'($urandom_range(3, 30));
         repeat (hops) begin
            ev = longhaul ? (($urandom_range(0, 19) != 0) ? lean : EV_NONE) : any_event();
            tick_plan_q.push_back(row(ev, 1'b1, coin(), any_alt(), any_yaw()));
         end
         repeat ($urandom_range(0, 3))
            tick_plan_q.push_back(row(EV_DOWN, 1'b1, coin(), any_alt(), any_yaw()));
         tick_plan_q.push_back(row(any_event(), 1'b0, coin(), any_alt(), any_yaw()));
      end
      repeat ($urandom_range(0, 3))
         tick_plan_q.push_back(row(any_event(), coin(), coin(), any_alt(), any_yaw()));
      tick_plan_q.push_back(row(any_event(), coin(), coin(), alt_between(1, 127),
                                yaw_near_zero()));
      tick_plan_q.push_back(row(any_event(), coin(), coin(), alt_between(-128, 0),
                                yaw_near_zero()));
   endtask

   // Offer every planned tick on the request channel. The expectation is
   // worked out at the edge where the beat is accepted, so the local state
   // advances in exactly the order the block sees the ticks.
   task automatic drive_plan();
      tick_row_type cur;
      rsp_type      pred;
      while (tick_plan_q.size() != 0) begin
         cur = tick_plan_q.pop_front();
         if (!calm && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data <= cur.beat;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         beats_in++;
         pred = advance_tick(cur.beat);
         tick_expect_q.push_back(cur.typed ? cur.want : pred);
      end
      req_valid <= 1'b0;
   endtask

   // Wait for every outstanding response, then for the pipeline to drain.
   task automatic settle();
      while (tick_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high on return so that writes can follow back to back.
   // The tail calibration duty drives no output, so nothing here tracks it.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      reg_writes++;
      case (idx)
         CSR_ALT_STEP:        cfg_alt_step = value[5:0];
         CSR_YAW_STEP:        cfg_yaw_step = value[7:0];
         CSR_TAKEOFF_ALT:     cfg_takeoff_alt = value[6:0];
         CSR_ALT_MAX:         cfg_alt_max = value[6:0];
         CSR_YAW_TOLERANCE:   cfg_yaw_tol = value[6:0];
         default: ;
      endcase
   endtask

   // One phase: program a full setting, plan exactly budget ticks of
   // flights mixed with bursts of random noise, drive them and drain.
   task automatic run_phase(logic [CSR_DATA_W-1:0] alt_step_v, yaw_step_v, takeoff_v,
                            alt_max_v, yaw_tol_v, tail_v, int budget, int gap_odds);
      write_reg(CSR_SPARE_LO, CSR_DATA_W'($urandom_range(0, 255)));
      write_reg(CSR_ALT_STEP, alt_step_v);
      write_reg(CSR_YAW_STEP, yaw_step_v);
      write_reg(CSR_TAKEOFF_ALT, takeoff_v);
      write_reg(CSR_ALT_MAX, alt_max_v);
      write_reg(CSR_YAW_TOLERANCE, yaw_tol_v);
      write_reg(CSR_CALIB_TAIL_DUTY, tail_v);
      write_reg(CSR_SPARE_HI, CSR_DATA_W'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
      settings++;
      while (tick_plan_q.size() < budget) begin
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 6))
               tick_plan_q.push_back(row(any_event(), coin(), coin(), any_alt(), any_yaw()));
         else
            plan_flight();
      end
      while (tick_plan_q.size() > budget) void'(tick_plan_q.pop_back());
      send_gap_odds = gap_odds;
      drive_plan();
      settle();
   endtask

   // Response side: rsp_ready drops in bursts. How often a burst starts is
   // redrawn from STALL_ODDS for each stretch, so that some stretches see no
   // stalls at all and others see many.
   int stall_left = 0;
   int stall_odds = 0;
   int mood_left = 0;

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else begin
         if (mood_left == 0) begin
            mood_left <= 64;
            stall_odds <= STALL_ODDS[$urandom_range(0, 2)];
         end else begin
            mood_left <= mood_left - 1;
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            stall_left <= $urandom_range(0, 11);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic report_mismatch(string what, rsp_type want, rsp_type got);
      string want_txt;
      string got_txt;
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         want_txt = $sformatf("mode %0d yaw %0d alt %0d duty %0d cal %0b zero %0b",
                              want.flight_mode, want.target_yaw_out, want.target_alt_out,
                              want.duty_override, want.alt_cal_request,
                              want.yaw_zero_request);
         got_txt = $sformatf("mode %0d yaw %0d alt %0d duty %0d cal %0b zero %0b",
                             got.flight_mode, got.target_yaw_out, got.target_alt_out,
                             got.duty_override, got.alt_cal_request,
                             got.yaw_zero_request);
         $display("tb: %s at beat %0d: want %s, got %s", what, beats_out, want_txt,
                  got_txt);
      end
   endtask

   // Every response beat is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (tick_expect_q.size() == 0) begin
            report_mismatch("response beat with nothing outstanding", '0, rsp_data);
         end else begin
            oldest_want = tick_expect_q.pop_front();
            if (rsp_data.flight_mode !== oldest_want.flight_mode ||
                rsp_data.target_yaw_out !== oldest_want.target_yaw_out ||
                rsp_data.target_alt_out !== oldest_want.target_alt_out ||
                rsp_data.duty_override !== oldest_want.duty_override ||
                rsp_data.alt_cal_request !== oldest_want.alt_cal_request ||
                rsp_data.yaw_zero_request !== oldest_want.yaw_zero_request)
               report_mismatch("response mismatch", oldest_want, rsp_data);
         end
      end
   end

   // Watchdog: a run in which no beat moves on any channel for too long is
   // hung, however it got there.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: no beat has moved for %0d cycles", STALL_LIMIT);
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table, run at the reset configuration. Rows with a typed
      // response are ones whose outcome is plain from the mode rules; the
      // rest are checked against the local model.
      // Idle: the switch off, extreme readings and unknown events change nothing.
      tick_plan_q.push_back(row(EV_NONE, 1'b0, 1'b0, 0, 0,
                                1'b1, outcome(MODE_IDLE, 0, 0, DUTY_ZERO, 1'b0, 1'b0)));
      tick_plan_q.push_back(row(EV_UP, 1'b0, 1'b0, -128, -32768,
                                1'b1, outcome(MODE_IDLE, 0, 0, DUTY_ZERO, 1'b0, 1'b0)));
      tick_plan_q.push_back(row(EV_JUNK_HI, 1'b1, 1'b0, 0, 0,
                                1'b1, outcome(MODE_IDLE, 0, 0, DUTY_ZERO, 1'b0, 1'b0)));
      tick_plan_q.push_back(row(EV_JUNK_LO, 1'b1, 1'b1, 127, 32767,
                                1'b1, outcome(MODE_IDLE, 0, 0, DUTY_ZERO, 1'b0, 1'b0)));
      // Uncalibrated, so an up press starts calibration; the switch going off
      // there returns to idle.
      tick_plan_q.push_back(row(EV_UP, 1'b1, 1'b0, 0, 0,
                                1'b1, outcome(MODE_CALIB, 0, 0, DUTY_ZERO, 1'b0, 1'b0)));
      tick_plan_q.push_back(row(EV_NONE, 1'b1, 1'b0, 0, 0,
                                1'b1, outcome(MODE_CALIB, 0, 0, DUTY_CAL, 1'b1, 1'b0)));
      tick_plan_q.push_back(row(EV_UP, 1'b0, 1'b1, 0, 0,
                                1'b1, outcome(MODE_IDLE, 0, 0, DUTY_NONE, 1'b0, 1'b0)));
      tick_plan_q.push_back(row(EV_UP, 1'b1, 1'b0, 0, 0,
                                1'b1, outcome(MODE_CALIB, 0, 0, DUTY_ZERO, 1'b0, 1'b0)));
      tick_plan_q.push_back(row(EV_NONE, 1'b1, 1'b1, 127, 32767,
                                1'b1, outcome(MODE_TAKEOFF, 0, 0, DUTY_CAL, 1'b1, 1'b1)));
      // Takeoff holds until the measured altitude reaches the takeoff target.
      tick_plan_q.push_back(row(EV_NONE, 1'b1, 1'b0, 9, 0,
                                1'b1, outcome(MODE_TAKEOFF, 0, 10, DUTY_NONE, 1'b0, 1'b0)));
      tick_plan_q.push_back(row(EV_NONE, 1'b1, 1'b0, 10, 0,
                                1'b1, outcome(MODE_FLYING, 0, 10, DUTY_NONE, 1'b0, 1'b0)));
      // Flying: every button, an unknown event, then down presses that take
      // the target below the takeoff altitude and start the landing.
      tick_plan_q.push_back(row(EV_RIGHT, 1'b1, 1'b0, 40, 100));
      tick_plan_q.push_back(row(EV_LEFT, 1'b1, 1'b1, 40, -100));
      tick_plan_q.push_back(row(EV_LEFT, 1'b1, 1'b0, 40, 0));
      tick_plan_q.push_back(row(EV_UP, 1'b1, 1'b0, 40, 0));
      tick_plan_q.push_back(row(EV_JUNK_MID, 1'b1, 1'b0, 40, 0));
      tick_plan_q.push_back(row(EV_DOWN, 1'b1, 1'b0, 40, 0));
      tick_plan_q.push_back(row(EV_DOWN, 1'b1, 1'b0, 40, 0));
      // Landing: yaw at the tolerance holds the target, yaw inside it drops
      // the target, and touchdown waits for the altitude to reach zero.
      tick_plan_q.push_back(row(EV_NONE, 1'b1, 1'b0, 50, 5));
      tick_plan_q.push_back(row(EV_NONE, 1'b1, 1'b0, 1, -4));
      tick_plan_q.push_back(row(EV_UP, 1'b0, 1'b1, -128, -32768));
      tick_plan_q.push_back(row(EV_NONE, 1'b0, 1'b0, 0, 0));
      // Once calibrated, an up press goes straight to takeoff; switching off
      // in flight lands.
      tick_plan_q.push_back(row(EV_UP, 1'b1, 1'b0, 0, 0,
                                1'b1, outcome(MODE_TAKEOFF, 0, 0, DUTY_ZERO, 1'b0, 1'b0)));
      tick_plan_q.push_back(row(EV_NONE, 1'b1, 1'b0, 50, 0));
      tick_plan_q.push_back(row(EV_RIGHT, 1'b0, 1'b0, 50, 0));
      tick_plan_q.push_back(row(EV_NONE, 1'b1, 1'b0, -128, 0));
      send_gap_odds = 4;
      drive_plan();
      settle();

      // Random flights over a range of settings: the lowest legal values, the
      // highest, all field bits set, all zero (steps and tolerance at zero
      // included), a random legal setting, and back to the reset values.
      run_phase(1, 1, 1, 1, 1, 0, 60, 10);
      run_phase(50, 180, 100, 100, 90, 100, 70, 3);
      run_phase(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 270, 6);
      run_phase(0, 0, 0, 0, 0, 0, 25, 4);
      run_phase(CSR_DATA_W'($urandom_range(1, 50)), CSR_DATA_W'($urandom_range(1, 180)),
                CSR_DATA_W'($urandom_range(1, 100)), CSR_DATA_W'($urandom_range(1, 100)),
                CSR_DATA_W'($urandom_range(1, 90)), CSR_DATA_W'($urandom_range(0, 100)),
                50, 5);
      // The closing phase runs with no idling on either side.
      calm = 1'b1;
      run_phase(CSR_DATA_W'(ALT_STEP_RESET), CSR_DATA_W'(YAW_STEP_RESET),
                CSR_DATA_W'(TAKEOFF_ALT_RESET), CSR_DATA_W'(ALT_MAX_RESET),
                CSR_DATA_W'(YAW_TOLERANCE_RESET), CSR_DATA_W'(CALIB_TAIL_RESET), 50, 0);

      $display("tb: %0d ticks sent, %0d responses checked, %0d register writes in %0d settings",
               beats_in, beats_out, reg_writes, settings);
      $display("tb: modes reached (landing..idle) %b, yaw target clipped %0d times",
               modes_seen[4:0], yaw_clips);
      if (mismatches == 0 && tick_expect_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: %0d mismatches", mismatches);
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
